// ===== src/quadric_patch_curvature_core_macros.svh =====
// assertion macros for the quadric patch curvature core
// depends on nothing; included by the top level, the only module that carries checks
`ifndef QUADRIC_PATCH_CURVATURE_CORE_MACROS_SVH
`define QUADRIC_PATCH_CURVATURE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check that is skipped while reset is high
`define QPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m check failed");
// check that also runs during reset
`define QPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m check failed");
`else
`define QPC_ASSERT(lbl, clk, rst, prop)
`define QPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/qpc_pkg.sv =====
// shared constants and register codes of the quadric patch curvature core
// depends on nothing
package qpc_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  // iterations per register stage in the root and divide pipelines
  localparam int SQRT_BITS_PER_STAGE = 2;
  localparam int DIV_BITS_PER_STAGE  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CONST = 3'd0,
    REG_X     = 3'd1,
    REG_Y     = 3'd2,
    REG_XX    = 3'd3,
    REG_XY    = 3'd4,
    REG_YY    = 3'd5
  } reg_idx_t;

endpackage

// ===== src/qpc_if.sv =====
// channel interfaces of the quadric patch curvature core
// depends on qpc_pkg
interface qpc_point_if #(
  parameter int WORD_BITS = qpc_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] x_coord;
  logic signed [WORD_BITS-1:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface qpc_result_if #(
  parameter int WORD_BITS = qpc_pkg::WORD_BITS,
  parameter int FRAC_BITS = qpc_pkg::FRAC_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] height;
  logic signed [WORD_BITS-1:0] curv_small;
  logic signed [WORD_BITS-1:0] curv_large;
  logic signed [FRAC_BITS+1:0] normal_x;
  logic signed [FRAC_BITS+1:0] normal_y;
  logic        [FRAC_BITS:0]   normal_z;
  modport source (output valid, output height, output curv_small, output curv_large,
                  output normal_x, output normal_y, output normal_z, input ready);
  modport sink (input valid, input height, input curv_small, input curv_large,
                input normal_x, input normal_y, input normal_z, output ready);
endinterface

interface qpc_cfg_if #(
  parameter int WORD_BITS = qpc_pkg::WORD_BITS
);
  logic                              valid;
  logic                              ready;
  logic [qpc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [WORD_BITS-1:0]              data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/qpc_delay.sv =====
// enabled delay line that carries side data along a pipeline
// depends on nothing
module qpc_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== src/qpc_sqrt.sv =====
// pipelined restoring integer square root, floor(sqrt(rad))
// depends on qpc_pkg for the default iterations per stage
module qpc_sqrt #(
  parameter int RAD_W = 66,
  parameter int BPS   = qpc_pkg::SQRT_BITS_PER_STAGE
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RAD_W-1:0]   rad,
  output logic [RAD_W/2-1:0] root
);

  localparam int STEPS  = RAD_W / 2;
  localparam int STAGES = (STEPS + BPS - 1) / BPS;
  localparam int PSTEPS = STAGES * BPS;
  localparam int PW     = 2 * PSTEPS;
  localparam int RW     = PSTEPS + 3;

  logic [RW-1:0]     rem_q  [STAGES];
  logic [PSTEPS-1:0] root_q [STAGES];
  logic [PW-1:0]     rad_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0]     rem_in, rem_nx, trial;
    logic [PSTEPS-1:0] root_in, root_nx;
    logic [PW-1:0]     rad_in, rad_nx;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = PW'(rad);
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // two radicand bits in, one root bit out per step
    always_comb begin
      rem_nx  = rem_in;
      root_nx = root_in;
      rad_nx  = rad_in;
      trial   = '0;
      for (int i = 0; i < BPS; i++) begin
        rem_nx = {rem_nx[RW-3:0], rad_nx[PW-1 -: 2]};
        rad_nx = rad_nx << 2;
        trial  = RW'({root_nx, 2'b01});
        if (rem_nx >= trial) begin
          rem_nx  = rem_nx - trial;
          root_nx = {root_nx[PSTEPS-2:0], 1'b1};
        end else begin
          root_nx = {root_nx[PSTEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_nx;
        root_q[s] <= root_nx;
        rad_q[s]  <= rad_nx;
      end
    end
  end

  assign root = root_q[STAGES-1][STEPS-1:0];

endmodule

// ===== src/qpc_div.sv =====
// pipelined restoring unsigned divider, floor(num / den)
// depends on qpc_pkg for the default iterations per stage
module qpc_div #(
  parameter int NW  = 50,
  parameter int DW  = 33,
  parameter int BPS = qpc_pkg::DIV_BITS_PER_STAGE
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  localparam int STAGES = (NW + BPS - 1) / BPS;
  localparam int PN     = STAGES * BPS;

  logic [DW:0]   rem_q [STAGES];
  logic [PN-1:0] quo_q [STAGES];
  logic [PN-1:0] num_q [STAGES];
  logic [DW-1:0] den_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW:0]   rem_in, rem_nx;
    logic [PN-1:0] quo_in, quo_nx, num_in, num_nx;
    logic [DW-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = PN'(num);
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      rem_nx = rem_in;
      quo_nx = quo_in;
      num_nx = num_in;
      for (int i = 0; i < BPS; i++) begin
        rem_nx = {rem_nx[DW-1:0], num_nx[PN-1]};
        num_nx = num_nx << 1;
        if (rem_nx >= {1'b0, den_in}) begin
          rem_nx = rem_nx - {1'b0, den_in};
          quo_nx = {quo_nx[PN-2:0], 1'b1};
        end else begin
          quo_nx = {quo_nx[PN-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_nx;
        quo_q[s] <= quo_nx;
        num_q[s] <= num_nx;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo = quo_q[STAGES-1][NW-1:0];

endmodule

// ===== src/quadric_patch_curvature_core.sv =====
// top level of the quadric patch curvature core: coefficient registers,
// product stages, root and divide pipelines; uses qpc_pkg, qpc_if,
// qpc_delay, qpc_sqrt, qpc_div and the assertion macro header
//
// usage:
//   cfg    write channel; index selects coefficient a, b, c, d, e, f (0..5),
//          data is the Q16.16 value; other indexes are dropped; always ready.
//          write only while no point is in flight.
//   point  one transaction per query point (x_coord, y_coord), Q16.16.
//   result one transaction per point: height, the two principal curvatures
//          (smaller magnitude first) and the unit normal.
// throughput: one point per cycle while the receiver keeps ready high.
// pipeline: input register, 3 product stages, ceil((max(W,F)+1)/2) root stages,
//   one operand stage, ceil((max(W+2,F+1)+F)/2) divide stages and the output
//   register; 48 register stages at Q16.16 in 32-bit words. the divide sets the depth.
// stall: while the output register holds a transaction that is not taken,
//   the whole pipeline freezes and point.ready is low; nothing is lost.
// reset: synchronous; clears all coefficients to zero and empties the
//   pipeline. no clearing pass is needed.
`include "quadric_patch_curvature_core_macros.svh"

module quadric_patch_curvature_core #(
  parameter int WORD_BITS = qpc_pkg::WORD_BITS,
  parameter int FRAC_BITS = qpc_pkg::FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  qpc_cfg_if.sink      cfg,
  qpc_point_if.sink    point,
  qpc_result_if.source result
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  // root widths: radicand covers gx^2+gy^2+2^2F and (d-f)^2+e^2
  localparam int SQ_OUT = ((W > F) ? W : F) + 1;
  localparam int SQ_IN  = 2 * SQ_OUT;
  localparam int SQ_STAGES =
    (SQ_OUT + qpc_pkg::SQRT_BITS_PER_STAGE - 1) / qpc_pkg::SQRT_BITS_PER_STAGE;

  // divide widths: numerator magnitude and scaled dividend
  localparam int NB    = ((W + 2) > (F + 1)) ? (W + 2) : (F + 1);
  localparam int DIV_N = NB + F;
  localparam int DIV_STAGES =
    (DIV_N + qpc_pkg::DIV_BITS_PER_STAGE - 1) / qpc_pkg::DIV_BITS_PER_STAGE;

  localparam int LAT = 4 + SQ_STAGES + 1 + DIV_STAGES + 1;

  localparam logic signed [2*W-1:0] SAT_HI = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W-1:0] SAT_LO = {{(W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]   MAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   MIN_W  = {1'b1, {(W-1){1'b0}}};
  localparam logic [F:0]            NZ_ONE = {1'b1, {F{1'b0}}};

  // saturate a wide signed value to one word
  function automatic logic signed [W-1:0] sat_w(input logic signed [2*W-1:0] v);
    logic signed [W-1:0] r;
    if (v > SAT_HI) begin
      r = MAX_W;
    end else if (v < SAT_LO) begin
      r = MIN_W;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // fixed point product, floor of the shifted exact product, saturated
  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    return sat_w(p >>> F);
  endfunction

  // coefficient registers
  logic signed [W-1:0] coef_const, coef_x, coef_y, coef_xx, coef_xy, coef_yy;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_const <= '0;
      coef_x     <= '0;
      coef_y     <= '0;
      coef_xx    <= '0;
      coef_xy    <= '0;
      coef_yy    <= '0;
    end else if (cfg.valid) begin
      case (qpc_pkg::reg_idx_t'(cfg.index))
        qpc_pkg::REG_CONST: coef_const <= cfg.data;
        qpc_pkg::REG_X:     coef_x     <= cfg.data;
        qpc_pkg::REG_Y:     coef_y     <= cfg.data;
        qpc_pkg::REG_XX:    coef_xx    <= cfg.data;
        qpc_pkg::REG_XY:    coef_xy    <= cfg.data;
        qpc_pkg::REG_YY:    coef_yy    <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline advance: the output register is free or being taken
  logic           en;
  logic [LAT-1:0] vld;

  assign en          = !vld[LAT-1] || result.ready;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  // stage 0: input register
  logic signed [W-1:0] x0, y0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= point.x_coord;
      y0 <= point.y_coord;
    end
  end

  // stage 1: first-level products
  logic signed [W-1:0] p_xx, p_xy, p_yy, p_bx, p_cy, p_dx, p_ey, p_ex, p_fy;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx <= qmul(x0, x0);
      p_xy <= qmul(x0, y0);
      p_yy <= qmul(y0, y0);
      p_bx <= qmul(coef_x, x0);
      p_cy <= qmul(coef_y, y0);
      p_dx <= qmul(coef_xx, x0);
      p_ey <= qmul(coef_xy, y0);
      p_ex <= qmul(coef_xy, x0);
      p_fy <= qmul(coef_yy, y0);
    end
  end

  // stage 2: quadratic products, gradient, linear part of the height
  logic signed [W-1:0] p_dxx, p_exy, p_fyy, s2_gx, s2_gy;
  logic signed [W+1:0] s2_hlin;
  logic signed [W+2:0] gx_sum, gy_sum;

  always_comb begin
    gx_sum = (W+3)'(coef_x) + ((W+3)'(p_dx) <<< 1) + (W+3)'(p_ey);
    gy_sum = (W+3)'(coef_y) + (W+3)'(p_ex) + ((W+3)'(p_fy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dxx   <= qmul(coef_xx, p_xx);
      p_exy   <= qmul(coef_xy, p_xy);
      p_fyy   <= qmul(coef_yy, p_yy);
      s2_gx   <= sat_w((2*W)'(gx_sum));
      s2_gy   <= sat_w((2*W)'(gy_sum));
      s2_hlin <= (W+2)'(coef_const) + (W+2)'(p_bx) + (W+2)'(p_cy);
    end
  end

  // stage 3: height, squared gradient length, discriminant
  logic signed [W+2:0]   h_sum;
  logic signed [2*W-1:0] gx_sq, gy_sq, e_sq;
  logic signed [W:0]     d_minus_f;
  logic signed [2*W+1:0] dmf_sq;
  logic signed [W-1:0]   s3_h, s3_gx, s3_gy;
  logic [SQ_IN-1:0]      s3_lsq, s3_rsq;

  always_comb begin
    h_sum     = (W+3)'(s2_hlin) + (W+3)'(p_dxx) + (W+3)'(p_exy) + (W+3)'(p_fyy);
    gx_sq     = s2_gx * s2_gx;
    gy_sq     = s2_gy * s2_gy;
    d_minus_f = (W+1)'(coef_xx) - (W+1)'(coef_yy);
    dmf_sq    = d_minus_f * d_minus_f;
    e_sq      = coef_xy * coef_xy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_h   <= sat_w((2*W)'(h_sum));
      s3_gx  <= s2_gx;
      s3_gy  <= s2_gy;
      s3_lsq <= SQ_IN'($unsigned(gx_sq)) + SQ_IN'($unsigned(gy_sq))
                + (SQ_IN'(1) << (2 * F));
      s3_rsq <= SQ_IN'($unsigned(dmf_sq)) + SQ_IN'($unsigned(e_sq));
    end
  end

  // root pipelines: gradient length and eigenvalue spread
  logic [SQ_OUT-1:0]   len_root, spread_root;
  logic [3*W-1:0]      sq_side;
  logic signed [W-1:0] sq_h, sq_gx, sq_gy;

  qpc_sqrt #(.RAD_W(SQ_IN)) u_len_sqrt (
    .clk (clk),
    .en  (en),
    .rad (s3_lsq),
    .root(len_root)
  );

  qpc_sqrt #(.RAD_W(SQ_IN)) u_spread_sqrt (
    .clk (clk),
    .en  (en),
    .rad (s3_rsq),
    .root(spread_root)
  );

  qpc_delay #(.WIDTH(3*W), .DEPTH(SQ_STAGES)) u_sq_side (
    .clk(clk),
    .en (en),
    .d  ({s3_h, s3_gx, s3_gy}),
    .q  (sq_side)
  );

  assign {sq_h, sq_gx, sq_gy} = sq_side;

  // operand stage: magnitudes and signs of the five quotients
  logic signed [NB:0]  d_plus_f, num_p, num_m;
  logic [NB-1:0]       mag_p, mag_m, mag_gx, mag_gy;
  logic [DIV_N-1:0]    pr_kp, pr_km, pr_nx, pr_ny, pr_nz;
  logic [SQ_OUT-1:0]   pr_len;
  logic signed [W-1:0] pr_h;
  logic                pr_neg_p, pr_neg_m, pr_pos_gx, pr_pos_gy;

  always_comb begin
    d_plus_f = (NB+1)'(coef_xx) + (NB+1)'(coef_yy);
    num_p    = d_plus_f + $signed((NB+1)'(spread_root));
    num_m    = d_plus_f - $signed((NB+1)'(spread_root));
    mag_p    = num_p[NB] ? NB'(-num_p) : NB'(num_p);
    mag_m    = num_m[NB] ? NB'(-num_m) : NB'(num_m);
    // most negative gradient keeps its full magnitude
    mag_gx   = NB'($unsigned(sq_gx[W-1] ? -sq_gx : sq_gx));
    mag_gy   = NB'($unsigned(sq_gy[W-1] ? -sq_gy : sq_gy));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_kp     <= {mag_p, {F{1'b0}}};
      pr_km     <= {mag_m, {F{1'b0}}};
      pr_nx     <= {mag_gx, {F{1'b0}}};
      pr_ny     <= {mag_gy, {F{1'b0}}};
      pr_nz     <= DIV_N'(1) << (2 * F);
      pr_len    <= len_root;
      pr_h      <= sq_h;
      pr_neg_p  <= num_p[NB];
      pr_neg_m  <= num_m[NB];
      pr_pos_gx <= !sq_gx[W-1] && (sq_gx != '0);
      pr_pos_gy <= !sq_gy[W-1] && (sq_gy != '0);
    end
  end

  // divide pipelines, one per quotient, all sharing the length as divisor
  logic [DIV_N-1:0]    q_kp, q_km, q_nx, q_ny, q_nz;
  logic [W+3:0]        dv_side;
  logic signed [W-1:0] dv_h;
  logic                dv_neg_p, dv_neg_m, dv_pos_gx, dv_pos_gy;

  qpc_div #(.NW(DIV_N), .DW(SQ_OUT)) u_div_kp (
    .clk(clk), .en(en), .num(pr_kp), .den(pr_len), .quo(q_kp)
  );

  qpc_div #(.NW(DIV_N), .DW(SQ_OUT)) u_div_km (
    .clk(clk), .en(en), .num(pr_km), .den(pr_len), .quo(q_km)
  );

  qpc_div #(.NW(DIV_N), .DW(SQ_OUT)) u_div_nx (
    .clk(clk), .en(en), .num(pr_nx), .den(pr_len), .quo(q_nx)
  );

  qpc_div #(.NW(DIV_N), .DW(SQ_OUT)) u_div_ny (
    .clk(clk), .en(en), .num(pr_ny), .den(pr_len), .quo(q_ny)
  );

  qpc_div #(.NW(DIV_N), .DW(SQ_OUT)) u_div_nz (
    .clk(clk), .en(en), .num(pr_nz), .den(pr_len), .quo(q_nz)
  );

  qpc_delay #(.WIDTH(W+4), .DEPTH(DIV_STAGES)) u_div_side (
    .clk(clk),
    .en (en),
    .d  ({pr_h, pr_neg_p, pr_neg_m, pr_pos_gx, pr_pos_gy}),
    .q  (dv_side)
  );

  assign {dv_h, dv_neg_p, dv_neg_m, dv_pos_gx, dv_pos_gy} = dv_side;

  // final stage: sign, saturation, ordering by magnitude
  logic signed [W-1:0] k_p, k_m;
  logic [W-1:0]        kmag_p, kmag_m;
  logic                big_p, big_m, swap;
  logic signed [F+1:0] nx_val, ny_val;

  always_comb begin
    big_p  = |q_kp[DIV_N-1:W-1];
    big_m  = |q_km[DIV_N-1:W-1];
    if (dv_neg_p) begin
      k_p = big_p ? MIN_W : -$signed(q_kp[W-1:0]);
    end else begin
      k_p = big_p ? MAX_W : $signed(q_kp[W-1:0]);
    end
    if (dv_neg_m) begin
      k_m = big_m ? MIN_W : -$signed(q_km[W-1:0]);
    end else begin
      k_m = big_m ? MAX_W : $signed(q_km[W-1:0]);
    end
    kmag_p = k_p[W-1] ? W'(-k_p) : W'(k_p);
    kmag_m = k_m[W-1] ? W'(-k_m) : W'(k_m);
    swap   = kmag_p > kmag_m;
    nx_val = dv_pos_gx ? -$signed((F+2)'(q_nx[F:0])) : $signed((F+2)'(q_nx[F:0]));
    ny_val = dv_pos_gy ? -$signed((F+2)'(q_ny[F:0])) : $signed((F+2)'(q_ny[F:0]));
  end

  logic signed [W-1:0] out_height, out_small, out_large;
  logic signed [F+1:0] out_nx, out_ny;
  logic [F:0]          out_nz;

  always_ff @(posedge clk) begin
    if (en) begin
      out_height <= dv_h;
      out_small  <= swap ? k_m : k_p;
      out_large  <= swap ? k_p : k_m;
      out_nx     <= nx_val;
      out_ny     <= ny_val;
      out_nz     <= q_nz[F:0];
    end
  end

  assign result.valid      = vld[LAT-1];
  assign result.height     = out_height;
  assign result.curv_small = out_small;
  assign result.curv_large = out_large;
  assign result.normal_x   = out_nx;
  assign result.normal_y   = out_ny;
  assign result.normal_z   = out_nz;

  // checks
  `QPC_ASSERT(a_curv_order, clk, rst, result.valid |-> ($unsigned(out_small[W-1] ? -out_small : out_small) <= $unsigned(out_large[W-1] ? -out_large : out_large)))
  `QPC_ASSERT(a_nz_unit, clk, rst, result.valid |-> (out_nz <= NZ_ONE))
  `QPC_ASSERT(a_freeze, clk, rst, !en |=> $stable(vld))
  `QPC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (vld == '0))

endmodule
